### sv/response_health_monitor_core_defines.svh
// Assertion macros shared by the response health monitor RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RESPONSE_HEALTH_MONITOR_CORE_DEFINES_SVH
`define RESPONSE_HEALTH_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rhm_pkg.sv
// Shared types and constants for the response health monitor.
// No dependencies; used by rhm_divider and response_health_monitor_core.
package rhm_pkg;

    localparam int unsigned CNT_W          = 32;
    localparam int unsigned SUM_W          = 48;
    localparam int unsigned MEAN_W         = 16;
    localparam int unsigned LEN_W          = 10;
    localparam int unsigned SENT_W         = 9;
    localparam int unsigned CODE_W         = 8;
    localparam int unsigned LIMIT_W        = 16;
    localparam int unsigned DEN_W          = 10;
    localparam int unsigned PROD_W         = CNT_W + DEN_W;
    localparam int unsigned DIV_CNT_W      = $clog2(MEAN_W + 1);
    localparam int unsigned APB_DATA_W     = 32;
    localparam int unsigned APB_ADDR_W     = 3;

    localparam logic [LEN_W-1:0]   MAX_REPLY_BYTES  = LEN_W'(512);
    localparam logic [LEN_W-1:0]   MIN_CODED_REPLY  = LEN_W'(3);
    localparam int unsigned        ERROR_BIT_POS    = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET      = LIMIT_W'(10);
    localparam logic [DEN_W-1:0]   DEN_RESET        = DEN_W'(20);

    // register index (byte address bit 2)
    localparam logic REG_CRASH_LIMIT = 1'b0;
    localparam logic REG_RATIO_DEN   = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_UNSET = 2'd0,
        VERDICT_PASS  = 2'd1,
        VERDICT_FAIL  = 2'd2,
        VERDICT_CRASH = 2'd3
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_WAIT,
        ST_MUL,
        ST_CMP,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic [1:0]        verdict;
        logic              crash_suspected;
        logic [CNT_W-1:0]  crash_time_ms;
        logic [CNT_W-1:0]  frames_total;
        logic [CNT_W-1:0]  accepted_total;
        logic [CNT_W-1:0]  rejected_total;
        logic [CNT_W-1:0]  timeout_total;
        logic [CNT_W-1:0]  longest_streak;
        logic [MEAN_W-1:0] mean_response_ms;
        logic [MEAN_W-1:0] peak_response_ms;
        logic [CNT_W-1:0]  tx_byte_total;
        logic [CNT_W-1:0]  rx_byte_total;
    } stats_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [MEAN_W-1:0] quotient;
    } div_rsp_t;

endpackage

### sv/rhm_divider.sv
// Iterative restoring divider: one quotient bit per cycle, 16-bit quotient.
// Depends on rhm_pkg. Caller guarantees dividend < divisor * 2**16, divisor != 0.
module rhm_divider (
    input  logic             clk,
    input  logic             rst_n,
    input  rhm_pkg::div_req_t req,
    output rhm_pkg::div_rsp_t rsp
);
    import rhm_pkg::*;

    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [MEAN_W-1:0]    shift_reg, shift_next;
    logic [CNT_W-1:0]     divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        shift_reg   <= shift_next;
        divisor_reg <= divisor_next;
    end

    always_comb
    begin
        trial        = {rem_reg, shift_reg[MEAN_W-1]};
        diff         = trial - {1'b0, divisor_reg};
        rem_next     = rem_reg;
        shift_next   = shift_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (req.start)
        begin
            // upper part is already below the divisor
            rem_next     = req.dividend[SUM_W-1:MEAN_W];
            shift_next   = req.dividend[MEAN_W-1:0];
            divisor_next = req.divisor;
            cnt_next     = DIV_CNT_W'(MEAN_W);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[CNT_W])
            begin
                rem_next   = diff[CNT_W-1:0];
                shift_next = {shift_reg[MEAN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next   = trial[CNT_W-1:0];
                shift_next = {shift_reg[MEAN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = shift_reg;

endmodule

### sv/response_health_monitor_core.sv
// Response health monitor: per-record traffic, timeout and latency statistics.
// Depends on rhm_pkg, rhm_divider and response_health_monitor_core_defines.svh.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | sink      | in_valid / in_stall  | one record (six fields)
//  out     | source    | out_valid / out_stall| statistics word (twelve fields)
//  apb     | slave     | psel/penable/pready  | two config registers, 0x0, 0x4
//
// A record goes through update and publish, plus a wait on the 16-step serial
// mean divider for a reply and ratio-test multiply and compare if run-ending.
// A new record is taken once the previous one is published; a result word
// waiting in the output register does not hold off the next record.
// Reset clears all statistics and loads the register defaults.
// A stalled output holds the block in its publish step until the word is taken.
`include "response_health_monitor_core_defines.svh"

module response_health_monitor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [8:0]  frame_bytes,
    input  logic [9:0]  response_length,
    input  logic [7:0]  response_code_byte,
    input  logic [15:0] response_time_ms,
    input  logic [31:0] elapsed_ms,
    input  logic        run_ending,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  verdict,
    output logic        crash_suspected,
    output logic [31:0] crash_time_ms,
    output logic [31:0] frames_total,
    output logic [31:0] accepted_total,
    output logic [31:0] rejected_total,
    output logic [31:0] timeout_total,
    output logic [31:0] longest_streak,
    output logic [15:0] mean_response_ms,
    output logic [15:0] peak_response_ms,
    output logic [31:0] tx_byte_total,
    output logic [31:0] rx_byte_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rhm_pkg::*;

    state_t               state_reg, state_next;
    stats_t               stats_reg, stats_next;
    stats_t               out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]     streak_reg, streak_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     replies_reg, replies_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [PROD_W-1:0]    prod_reg, prod_next;

    // captured record
    logic [SENT_W-1:0]    sent_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [CODE_W-1:0]    code_reg;
    logic [MEAN_W-1:0]    rtime_reg;
    logic [CNT_W-1:0]     now_reg;
    logic                 ending_reg;

    logic                 accept_in;
    logic                 cfg_write;
    logic [LEN_W-1:0]     len_clamped;
    logic [CNT_W-1:0]     streak_inc;
    logic                 counted;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            den_reg   <= DEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_CRASH_LIMIT: limit_reg <= pwdata[LIMIT_W-1:0];
                REG_RATIO_DEN:   den_reg   <= pwdata[DEN_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CRASH_LIMIT: prdata = APB_DATA_W'(limit_reg);
            REG_RATIO_DEN:   prdata = APB_DATA_W'(den_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            sent_reg   <= frame_bytes;
            len_reg    <= response_length;
            code_reg   <= response_code_byte;
            rtime_reg  <= response_time_ms;
            now_reg    <= elapsed_ms;
            ending_reg <= run_ending;
        end
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stats_reg     <= '0;
            out_valid_reg <= 1'b0;
            streak_reg    <= '0;
            sum_reg       <= '0;
            replies_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            stats_reg     <= stats_next;
            out_valid_reg <= out_valid_next;
            streak_reg    <= streak_next;
            sum_reg       <= sum_next;
            replies_reg   <= replies_next;
        end
    end

    always_comb
    begin
        len_clamped = (len_reg > MAX_REPLY_BYTES) ? MAX_REPLY_BYTES : len_reg;
        streak_inc  = (streak_reg == '1) ? streak_reg : streak_reg + CNT_W'(1);
        counted     = (replies_reg != '1);
    end

    always_comb
    begin
        state_next     = state_reg;
        stats_next     = stats_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        streak_next    = streak_reg;
        sum_next       = sum_reg;
        replies_next   = replies_reg;
        prod_next      = prod_reg;
        div_req.start    = 1'b0;
        div_req.dividend = sum_reg;
        div_req.divisor  = replies_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                    state_next = ST_UPDATE;
            end

            ST_UPDATE:
            begin
                stats_next.tx_byte_total = stats_reg.tx_byte_total + CNT_W'(sent_reg);
                stats_next.rx_byte_total = stats_reg.rx_byte_total + CNT_W'(len_clamped);
                stats_next.frames_total  = stats_reg.frames_total + CNT_W'(1);
                if (len_clamped == '0)
                begin
                    stats_next.timeout_total = stats_reg.timeout_total + CNT_W'(1);
                    streak_next = streak_inc;
                    if (streak_inc > stats_reg.longest_streak)
                        stats_next.longest_streak = streak_inc;
                    if (streak_inc >= CNT_W'(limit_reg) && !stats_reg.crash_suspected)
                    begin
                        stats_next.crash_suspected = 1'b1;
                        stats_next.crash_time_ms   = now_reg;
                    end
                end
                else
                begin
                    streak_next = '0;
                    // replies of one or two bytes carry no code
                    if (len_clamped >= MIN_CODED_REPLY && code_reg[ERROR_BIT_POS])
                        stats_next.rejected_total = stats_reg.rejected_total + CNT_W'(1);
                    else
                        stats_next.accepted_total = stats_reg.accepted_total + CNT_W'(1);
                    if (rtime_reg > stats_reg.peak_response_ms)
                        stats_next.peak_response_ms = rtime_reg;
                end

                if (len_clamped != '0 && counted)
                begin
                    sum_next         = sum_reg + SUM_W'(rtime_reg);
                    replies_next     = replies_reg + CNT_W'(1);
                    div_req.start    = 1'b1;
                    div_req.dividend = sum_next;
                    div_req.divisor  = replies_next;
                    state_next       = ST_DIV_WAIT;
                end
                else if (ending_reg)
                    state_next = ST_MUL;
                else
                    state_next = ST_PUBLISH;
            end

            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    stats_next.mean_response_ms = div_rsp.quotient;
                    state_next = ending_reg ? ST_MUL : ST_PUBLISH;
                end
            end

            ST_MUL:
            begin
                prod_next  = PROD_W'(stats_reg.accepted_total) * PROD_W'(den_reg);
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                if (stats_reg.crash_suspected)
                    stats_next.verdict = VERDICT_CRASH;
                else if (stats_reg.frames_total != '0)
                    stats_next.verdict = (prod_reg > PROD_W'(stats_reg.frames_total))
                                         ? VERDICT_FAIL : VERDICT_PASS;
                state_next = ST_PUBLISH;
            end

            ST_PUBLISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = stats_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    rhm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid        = out_valid_reg;
    assign verdict          = out_reg.verdict;
    assign crash_suspected  = out_reg.crash_suspected;
    assign crash_time_ms    = out_reg.crash_time_ms;
    assign frames_total     = out_reg.frames_total;
    assign accepted_total   = out_reg.accepted_total;
    assign rejected_total   = out_reg.rejected_total;
    assign timeout_total    = out_reg.timeout_total;
    assign longest_streak   = out_reg.longest_streak;
    assign mean_response_ms = out_reg.mean_response_ms;
    assign peak_response_ms = out_reg.peak_response_ms;
    assign tx_byte_total    = out_reg.tx_byte_total;
    assign rx_byte_total    = out_reg.rx_byte_total;

    `RHM_ASSERT_NEXT(a_accept_starts_update, clk, rst_n, accept_in, state_reg == ST_UPDATE, "record accepted without update step")
    `RHM_ASSERT_NOW(a_div_done_in_wait, clk, rst_n, div_rsp.done, state_reg == ST_DIV_WAIT, "divider finished outside wait step")
    `RHM_ASSERT_NEXT(a_crash_sticky, clk, rst_n, stats_reg.crash_suspected, stats_reg.crash_suspected, "crash flag cleared")
    `RHM_ASSERT_NOW(a_mean_below_peak, clk, rst_n, 1'b1, stats_reg.mean_response_ms <= stats_reg.peak_response_ms, "mean above peak")

endmodule
